// ----- design/ffha_pkg.sv -----
package ffha_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int HB_W = 21;
	localparam int KW = 28;

	localparam logic [1:0] FN_INIT = 2'd0;
	localparam logic [1:0] FN_ALLOC = 2'd1;
	localparam logic [1:0] FN_FREE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;
	localparam logic [1:0] ST_SMALL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 1'd1;

	localparam logic [HB_W-1:0] MIN_AREA = 21'd45;
	localparam logic [32:0] BASE_OFS = 33'd47;
	localparam logic [31:0] REQ_BIAS = 32'd27;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] request_bytes;
		logic [31:0] address;
	} ffha_cmd_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  status;
	} ffha_rsp_t;

endpackage

// ----- design/ffha_ram.sv -----
module ffha_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/first_fit_heap_allocator.sv -----
// Next-fit heap allocator over 16-byte granules.
// Configure heap_start and heap_bytes through cfg_we/cfg_index/cfg_data while
// busy is low, then issue an init command. A command is taken when start is
// high and busy is low; cmd.func selects init, allocate or release.
// Every command yields one result on rsp, marked by a one-cycle done strobe;
// the receiver must take it in that cycle. busy falls in the cycle done rises,
// so the next command may be issued then.
// Unused codes, null release and rejected requests are answered from idle.
// Allocate reads the chunk list memory once per chunk visited on the walk
// from the rover, and splits the chunk when it is larger than needed. Release
// stops early when the address is not a chunk head.
// Init clears the chunk list memory, one entry per cycle.
// After reset the same clearing pass runs with busy high; configuration
// writes are taken throughout.
module first_fit_heap_allocator #(
	parameter int MAX_GRANULES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  ffha_pkg::ffha_cmd_t            cmd,
	output logic                           done,
	output ffha_pkg::ffha_rsp_t            rsp,
	input  logic                           cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import ffha_pkg::*;

	localparam int DEPTH = MAX_GRANULES + 1;
	localparam int GW = $clog2(DEPTH);
	localparam int AW = GW + 2;
	localparam logic [GW-1:0] MAX_G = GW'(MAX_GRANULES);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_INIT_HD, S_INIT_END, S_AL_RD, S_AL_CHK, S_AL_SPLIT,
		S_FR_RDG, S_FR_CHKG, S_FR_CHKN, S_FR_KILLN, S_FR_RDP, S_FR_CHKP, S_FR_KILLG
	} state_t;

	function automatic logic [GW-1:0] clampg(input logic [GW-1:0] g);
		return (g <= MAX_G) ? g : '0;
	endfunction

	state_t          state_q;
	logic [31:0]     heap_start_q;
	logic [HB_W-1:0] heap_bytes_q;
	logic [31:0]     base_q, ibase_q;
	logic [GW-1:0]   total_q, rover_q, count_q, clr_q, cnt_q;
	logic [GW-1:0]   g_q, n_q, p_q, s_q, nold_q, an_next_q;
	logic            init_q, bad_q, gh_q;
	logic [KW-1:0]   k_q;

	logic            a_we, b_we;
	logic [GW-1:0]   a_waddr, a_raddr, b_waddr, b_raddr;
	logic [AW-1:0]   a_wdata, a_rdata;
	logic [GW-1:0]   b_wdata, b_rdata;

	logic            a_head, a_used;
	logic [GW-1:0]   a_next, al_n, al_span, al_s, fr_nn;
	logic            al_fit, al_split;
	logic [32:0]     i_base, i_end, i_diff;
	logic            i_bad;
	logic [GW-1:0]   i_count;
	logic [31:0]     req_sum, fr_diff, g_addr;
	logic [KW-1:0]   fr_g;

	ffha_ram #(.DEPTH(DEPTH), .WIDTH(AW)) u_link_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	ffha_ram #(.DEPTH(DEPTH), .WIDTH(GW)) u_prev_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	assign a_head = a_rdata[GW+1];
	assign a_used = a_rdata[GW];
	assign a_next = a_rdata[GW-1:0];

	assign al_n = clampg(a_next);
	assign al_span = al_n - g_q;
	assign al_fit = !a_used && (al_n > g_q) && (KW'(al_span) >= k_q);
	assign al_split = k_q < KW'(al_span);
	assign al_s = g_q + k_q[GW-1:0];
	assign fr_nn = clampg(a_next);

	assign i_base = (33'(heap_start_q) + BASE_OFS) & ~33'd15;
	assign i_end = (33'(heap_start_q) + 33'(heap_bytes_q)) & ~33'd15;
	assign i_bad = (heap_bytes_q < MIN_AREA) || (i_end <= i_base);
	assign i_diff = i_end - i_base;
	assign i_count = (i_diff[32:4] > 29'(MAX_GRANULES)) ? MAX_G : i_diff[GW+3:4];

	assign req_sum = cmd.request_bytes + REQ_BIAS;
	assign fr_diff = cmd.address - base_q;
	assign fr_g = fr_diff[31:4];
	assign g_addr = base_q + (32'(g_q) << 4);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		a_we = 1'b0;
		a_waddr = g_q;
		a_wdata = '0;
		a_raddr = g_q;
		b_we = 1'b0;
		b_waddr = g_q;
		b_wdata = '0;
		b_raddr = g_q;
		unique case (state_q)
			S_CLR: begin
				a_we = 1'b1;
				a_waddr = clr_q;
				b_we = 1'b1;
				b_waddr = clr_q;
			end
			S_INIT_HD: begin
				a_we = 1'b1;
				a_waddr = '0;
				a_wdata = {2'b10, total_q};
				b_we = 1'b1;
				b_waddr = '0;
				b_wdata = total_q;
			end
			S_INIT_END: begin
				a_we = 1'b1;
				a_waddr = total_q;
				a_wdata = {2'b11, {GW{1'b0}}};
				b_we = 1'b1;
				b_waddr = total_q;
			end
			S_AL_CHK: begin
				a_raddr = al_n;
				if (al_fit && al_split) begin
					a_we = 1'b1;
					a_waddr = al_s;
					a_wdata = {2'b10, al_n};
					b_we = 1'b1;
					b_waddr = al_s;
					b_wdata = g_q;
				end else if (al_fit) begin
					a_we = 1'b1;
					a_wdata = {a_head, 1'b1, a_next};
				end
			end
			S_AL_SPLIT: begin
				a_we = 1'b1;
				a_wdata = {gh_q, 1'b1, s_q};
				b_we = 1'b1;
				b_waddr = n_q;
				b_wdata = s_q;
			end
			S_FR_CHKG: begin
				a_raddr = clampg(a_next);
				if (a_head) begin
					a_we = 1'b1;
					a_wdata = {2'b10, a_next};
				end
			end
			S_FR_CHKN: begin
				if (!a_used) begin
					a_we = 1'b1;
					a_wdata = {2'b10, fr_nn};
					b_we = 1'b1;
					b_waddr = fr_nn;
					b_wdata = g_q;
				end
			end
			S_FR_KILLN: begin
				a_we = 1'b1;
				a_waddr = nold_q;
				a_wdata = {2'b00, an_next_q};
			end
			S_FR_RDP: begin
				a_raddr = p_q;
			end
			S_FR_CHKP: begin
				if (!a_used) begin
					a_we = 1'b1;
					a_waddr = p_q;
					a_wdata = {a_head, 1'b0, n_q};
					b_we = 1'b1;
					b_waddr = n_q;
					b_wdata = p_q;
				end
			end
			S_FR_KILLG: begin
				a_we = 1'b1;
				a_wdata = {2'b00, n_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_start_q <= '0;
			heap_bytes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEAP_START: heap_start_q <= cfg_data;
				CFG_HEAP_BYTES: heap_bytes_q <= cfg_data[HB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			init_q <= 1'b0;
			done <= 1'b0;
			rsp <= '0;
			total_q <= '0;
			rover_q <= '0;
			base_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAX_G) begin
						clr_q <= '0;
						state_q <= S_IDLE;
						if (init_q) begin
							init_q <= 1'b0;
							if (bad_q) begin
								done <= 1'b1;
								rsp <= '{addr: '0, status: ST_SMALL};
							end else begin
								total_q <= count_q;
								base_q <= ibase_q;
								state_q <= S_INIT_HD;
							end
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						unique case (cmd.func)
							FN_INIT: begin
								init_q <= 1'b1;
								bad_q <= i_bad;
								count_q <= i_count;
								ibase_q <= i_base[31:0];
								total_q <= '0;
								rover_q <= '0;
								state_q <= S_CLR;
							end
							FN_ALLOC: begin
								if (total_q == '0 || cmd.request_bytes == '0 ||
										cmd.request_bytes[31]) begin
									done <= 1'b1;
									rsp <= '{addr: '0, status: ST_NOFIT};
								end else begin
									k_q <= req_sum[31:4];
									g_q <= rover_q;
									cnt_q <= '0;
									state_q <= S_AL_RD;
								end
							end
							FN_FREE: begin
								if (cmd.address == '0) begin
									done <= 1'b1;
									rsp <= '{addr: '0, status: ST_OK};
								end else if (fr_diff[3:0] != 4'd0 ||
										fr_g >= KW'(total_q)) begin
									done <= 1'b1;
									rsp <= '{addr: '0, status: ST_BADADDR};
								end else begin
									g_q <= fr_g[GW-1:0];
									state_q <= S_FR_RDG;
								end
							end
							default: begin
								done <= 1'b1;
								rsp <= '{addr: '0, status: ST_OK};
							end
						endcase
					end
				end
				S_INIT_HD: state_q <= S_INIT_END;
				S_INIT_END: begin
					done <= 1'b1;
					rsp <= '{addr: '0, status: ST_OK};
					state_q <= S_IDLE;
				end
				S_AL_RD: state_q <= S_AL_CHK;
				S_AL_CHK: begin
					if (al_fit) begin
						if (al_split) begin
							gh_q <= a_head;
							s_q <= al_s;
							n_q <= al_n;
							state_q <= S_AL_SPLIT;
						end else begin
							rover_q <= al_n;
							done <= 1'b1;
							rsp <= '{addr: g_addr, status: ST_OK};
							state_q <= S_IDLE;
						end
					end else if (al_n == rover_q || cnt_q == total_q) begin
						done <= 1'b1;
						rsp <= '{addr: '0, status: ST_NOFIT};
						state_q <= S_IDLE;
					end else begin
						g_q <= al_n;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_AL_SPLIT: begin
					rover_q <= s_q;
					done <= 1'b1;
					rsp <= '{addr: g_addr, status: ST_OK};
					state_q <= S_IDLE;
				end
				S_FR_RDG: state_q <= S_FR_CHKG;
				S_FR_CHKG: begin
					if (!a_head) begin
						done <= 1'b1;
						rsp <= '{addr: '0, status: ST_BADADDR};
						state_q <= S_IDLE;
					end else begin
						n_q <= clampg(a_next);
						p_q <= clampg(b_rdata);
						state_q <= S_FR_CHKN;
					end
				end
				S_FR_CHKN: begin
					if (!a_used) begin
						nold_q <= n_q;
						an_next_q <= a_next;
						n_q <= fr_nn;
						state_q <= S_FR_KILLN;
					end else begin
						state_q <= S_FR_RDP;
					end
				end
				S_FR_KILLN: state_q <= S_FR_RDP;
				S_FR_RDP: state_q <= S_FR_CHKP;
				S_FR_CHKP: begin
					if (!a_used) begin
						rover_q <= p_q;
						state_q <= S_FR_KILLG;
					end else begin
						rover_q <= g_q;
						done <= 1'b1;
						rsp <= '{addr: '0, status: ST_OK};
						state_q <= S_IDLE;
					end
				end
				S_FR_KILLG: begin
					done <= 1'b1;
					rsp <= '{addr: '0, status: ST_OK};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
